// File: rtl/core/awdd_pkg.sv
// Shared constants and types for the accelerometer window delta detector.
package awdd_pkg;

  localparam int unsigned FracBits   = 4;
  localparam int unsigned MaxWindow  = 16;
  localparam int unsigned HistDepth  = 3;
  localparam int unsigned CountW     = $clog2(MaxWindow + 1);
  localparam int unsigned FillW      = $clog2(HistDepth + 1);
  localparam int unsigned HistIdxW   = $clog2(HistDepth);
  localparam int unsigned RawW       = 16;
  localparam int unsigned SumW       = 21;
  localparam int unsigned MeanW      = 20;
  localparam int unsigned TempW      = 15;
  localparam int unsigned LimitW     = 20;
  localparam int unsigned HsumW      = 22;
  localparam int unsigned NowW       = 21;

  // Serial divider lanes: dividend magnitude bits and divisor bits.
  localparam int unsigned DivW       = 24;
  localparam int unsigned DenW       = 5;
  localparam int unsigned DivSteps   = DivW;
  localparam int unsigned StepCntW   = $clog2(DivSteps);

  localparam int unsigned TempDen    = 17;
  localparam int unsigned TempOffset = 3653;

  localparam int unsigned InDataW    = 112;
  localparam int unsigned OutDataW   = 144;

  typedef enum logic {
    CFG_LOW_LIMIT  = 1'b0,
    CFG_HIGH_LIMIT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

endpackage

// File: rtl/core/awdd_div_lane.sv
// Bit-serial restoring divider lane: one quotient bit per step.
module awdd_div_lane import awdd_pkg::*; (
  input  logic            clk_i,
  input  div_ctrl_t       ctrl_i,
  input  logic [DivW-1:0] dividend_i,
  input  logic [DenW-1:0] divisor_i,
  output logic [DivW-1:0] quot_o
);

  logic [DenW-1:0] rem_q, rem_d;
  logic [DivW-1:0] acc_q, acc_d;
  logic [DenW-1:0] den_q;
  logic [DenW:0]   trial;
  logic [DenW:0]   diff;
  logic            fits;

  always_comb begin
    trial = {rem_q, acc_q[DivW-1]};
    diff  = trial - {1'b0, den_q};
    fits  = (trial >= {1'b0, den_q});
    rem_d = rem_q;
    acc_d = acc_q;
    if (ctrl_i.load) begin
      rem_d = '0;
      acc_d = dividend_i;
    end else if (ctrl_i.step) begin
      // The remainder stays below the divisor, so it fits in DenW bits.
      rem_d = fits ? diff[DenW-1:0] : trial[DenW-1:0];
      acc_d = {acc_q[DivW-2:0], fits};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    acc_q <= acc_d;
    if (ctrl_i.load) begin
      den_q <= divisor_i;
    end
  end

  assign quot_o = acc_q;

endmodule

// File: rtl/core/accel_window_delta_detector.sv
// Top level of the accelerometer window delta detector.
//
// Channel   Direction  Handshake                    Contents
// s_axis    in         s_axis_tvalid/s_axis_tready  sample or window close (tuser)
// m_axis    out        m_axis_tvalid/m_axis_tready  means, temperature, gyro, delta, alert
// cfg       in         cfg_we_i                     delta limit registers
//
// A sample transaction can be followed at once by the next one.
// A close transaction runs two passes of 24 steps through the bit-serial divider
// lanes (window means and temperature, then the Z history average), plus five
// bookkeeping states, before its result appears.
// Reset is asynchronous, clears the window and history and restores the default limits.
// Samples are still taken while a result waits on m_axis; a following close
// holds in its last state until the output register is free.
module accel_window_delta_detector import awdd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // accel_x, accel_y, accel_z, temp_raw, gyro_x_in, gyro_y_in, gyro_z_in
  input  logic [InDataW-1:0]  s_axis_tdata,
  // cmd
  input  logic [0:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // mean_x, mean_y, mean_z, temp_centideg, gyro_x_out, gyro_y_out,
  // gyro_z_out, z_change, alert
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_addr_i,
  input  logic [LimitW-1:0]   cfg_wdata_i
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DIV    = 8'b0000_0010,
    S_MEAN   = 8'b0000_0100,
    S_HSUM   = 8'b0000_1000,
    S_LOAD   = 8'b0001_0000,
    S_DIV2   = 8'b0010_0000,
    S_NOW    = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_e;

  state_e               state_q, state_d;
  logic [StepCntW-1:0]  step_cnt_q, step_cnt_d;

  logic signed [SumW-1:0]  sum_x_q, sum_y_q, sum_z_q;
  logic [CountW-1:0]       count_q;
  logic signed [MeanW-1:0] hist_q [HistDepth];
  logic [FillW-1:0]        fill_q;
  logic signed [RawW-1:0]  prev_z_q, prev_z_d;
  logic [LimitW-1:0]       low_limit_q, high_limit_q;
  logic                    out_valid_q;

  logic                    neg_x_q, neg_y_q, neg_z_q, neg_t_q, neg_h_q;
  logic signed [MeanW-1:0] mean_x_q, mean_y_q, mean_z_q;
  logic signed [TempW-1:0] temp_q;
  logic [RawW-1:0]         gyro_x_q, gyro_y_q, gyro_z_q;
  logic signed [HsumW-1:0] hsum_q;
  logic signed [NowW-1:0]  now_q;
  logic [OutDataW-1:0]     out_data_q;

  logic sample_acc, close_acc, out_free, steps_done;

  logic signed [RawW-1:0] accel_x, accel_y, accel_z, temp_raw;

  logic signed [SumW+FracBits-1:0] scaled_x, scaled_y, scaled_z;
  logic signed [SumW+FracBits-1:0] mag_x, mag_y, mag_z;
  logic signed [RawW+2:0]          temp5, temp5_mag;
  logic [DenW-1:0]                 den_win;
  logic signed [HsumW-1:0]         hsum_mag;

  div_ctrl_t       ctrl_win, ctrl_z;
  logic [DivW-1:0] dvd_z;
  logic [DenW-1:0] den_z;
  logic [DivW-1:0] quot_x, quot_y, quot_z, quot_t;

  logic signed [MeanW-1:0] mean_x_new, mean_y_new, mean_z_new;
  logic signed [TempW-1:0] temp_new;
  logic signed [NowW-1:0]  now_new, now_bias;
  logic signed [HsumW-1:0] diff, diff_mag;
  logic [LimitW-1:0]       change;
  logic                    alert;

  // Input field extraction.
  assign accel_x  = s_axis_tdata[15:0];
  assign accel_y  = s_axis_tdata[31:16];
  assign accel_z  = s_axis_tdata[47:32];
  assign temp_raw = s_axis_tdata[63:48];

  assign s_axis_tready = (state_q == S_IDLE);
  assign sample_acc    = s_axis_tvalid && s_axis_tready && !s_axis_tuser[0];
  assign close_acc     = s_axis_tvalid && s_axis_tready && s_axis_tuser[0];
  assign out_free      = !out_valid_q || m_axis_tready;
  assign steps_done    = (step_cnt_q == StepCntW'(DivSteps - 1));

  // Dividend magnitudes for the window means and the temperature.
  always_comb begin
    scaled_x  = {sum_x_q, {FracBits{1'b0}}};
    scaled_y  = {sum_y_q, {FracBits{1'b0}}};
    scaled_z  = {sum_z_q, {FracBits{1'b0}}};
    mag_x     = scaled_x[SumW+FracBits-1] ? -scaled_x : scaled_x;
    mag_y     = scaled_y[SumW+FracBits-1] ? -scaled_y : scaled_y;
    mag_z     = scaled_z[SumW+FracBits-1] ? -scaled_z : scaled_z;
    temp5     = ((RawW+3)'(temp_raw) <<< 2) + (RawW+3)'(temp_raw);
    temp5_mag = temp5[RawW+2] ? -temp5 : temp5;
    // An empty window has zero sums, so dividing by one gives zero means.
    den_win   = (count_q == '0) ? DenW'(1) : DenW'(count_q);
    hsum_mag  = hsum_q[HsumW-1] ? -hsum_q : hsum_q;
  end

  always_comb begin
    ctrl_win.load = close_acc;
    ctrl_win.step = (state_q == S_DIV);
    ctrl_z.load   = close_acc || (state_q == S_LOAD);
    ctrl_z.step   = (state_q == S_DIV) || (state_q == S_DIV2);
    if (state_q == S_LOAD) begin
      dvd_z = DivW'(hsum_mag);
      den_z = DenW'(fill_q);
    end else begin
      dvd_z = mag_z[DivW-1:0];
      den_z = den_win;
    end
  end

  awdd_div_lane u_div_x (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl_win),
    .dividend_i (mag_x[DivW-1:0]),
    .divisor_i  (den_win),
    .quot_o     (quot_x)
  );

  awdd_div_lane u_div_y (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl_win),
    .dividend_i (mag_y[DivW-1:0]),
    .divisor_i  (den_win),
    .quot_o     (quot_y)
  );

  awdd_div_lane u_div_z (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl_z),
    .dividend_i (dvd_z),
    .divisor_i  (den_z),
    .quot_o     (quot_z)
  );

  awdd_div_lane u_div_t (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl_win),
    .dividend_i (DivW'(temp5_mag)),
    .divisor_i  (DenW'(TempDen)),
    .quot_o     (quot_t)
  );

  // Signed results from the lane magnitudes, truncated toward zero.
  always_comb begin
    mean_x_new = neg_x_q ? -quot_x[MeanW-1:0] : quot_x[MeanW-1:0];
    mean_y_new = neg_y_q ? -quot_y[MeanW-1:0] : quot_y[MeanW-1:0];
    mean_z_new = neg_z_q ? -quot_z[MeanW-1:0] : quot_z[MeanW-1:0];
    temp_new   = (neg_t_q ? -quot_t[TempW-1:0] : quot_t[TempW-1:0])
                 + TempW'(TempOffset);
    now_new    = neg_h_q ? -quot_z[NowW-1:0] : quot_z[NowW-1:0];
  end

  // Delta against the previous integer value, and its truncated successor.
  always_comb begin
    diff     = HsumW'(now_q) - {{(HsumW-RawW-FracBits){prev_z_q[RawW-1]}},
                                prev_z_q, {FracBits{1'b0}}};
    diff_mag = diff[HsumW-1] ? -diff : diff;
    change   = diff_mag[LimitW-1:0];
    alert    = (change <= low_limit_q) || (change >= high_limit_q);
    now_bias = now_q + (now_q[NowW-1] ? NowW'((1 << FracBits) - 1) : NowW'(0));
    prev_z_d = now_bias[RawW+FracBits-1:FracBits];
  end

  always_comb begin
    state_d    = state_q;
    step_cnt_d = step_cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (close_acc) begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        step_cnt_d = step_cnt_q + StepCntW'(1);
        if (steps_done) begin
          step_cnt_d = '0;
          state_d    = S_MEAN;
        end
      end
      S_MEAN: state_d = S_HSUM;
      S_HSUM: state_d = S_LOAD;
      S_LOAD: state_d = S_DIV2;
      S_DIV2: begin
        step_cnt_d = step_cnt_q + StepCntW'(1);
        if (steps_done) begin
          step_cnt_d = '0;
          state_d    = S_NOW;
        end
      end
      S_NOW: state_d = S_FINISH;
      S_FINISH: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      step_cnt_q   <= '0;
      sum_x_q      <= '0;
      sum_y_q      <= '0;
      sum_z_q      <= '0;
      count_q      <= '0;
      for (int i = 0; i < HistDepth; i++) begin
        hist_q[i] <= '0;
      end
      fill_q       <= FillW'(1);
      prev_z_q     <= '0;
      low_limit_q  <= '0;
      high_limit_q <= '1;
      out_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      step_cnt_q <= step_cnt_d;

      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_addr_i))
          CFG_LOW_LIMIT:  low_limit_q  <= cfg_wdata_i;
          CFG_HIGH_LIMIT: high_limit_q <= cfg_wdata_i;
        endcase
      end

      if (close_acc) begin
        sum_x_q <= '0;
        sum_y_q <= '0;
        sum_z_q <= '0;
        count_q <= '0;
      end else if (sample_acc && (count_q < CountW'(MaxWindow))) begin
        sum_x_q <= sum_x_q + SumW'(accel_x);
        sum_y_q <= sum_y_q + SumW'(accel_y);
        sum_z_q <= sum_z_q + SumW'(accel_z);
        count_q <= count_q + CountW'(1);
      end

      // Entries past the fill count stay zero, so the sum may read them all.
      if (state_q == S_MEAN) begin
        if (fill_q == FillW'(HistDepth)) begin
          for (int i = 0; i < HistDepth - 1; i++) begin
            hist_q[i] <= hist_q[i+1];
          end
          hist_q[HistDepth-1] <= mean_z_new;
        end else begin
          hist_q[fill_q[HistIdxW-1:0]] <= mean_z_new;
          fill_q <= fill_q + FillW'(1);
        end
      end

      if ((state_q == S_FINISH) && out_free) begin
        prev_z_q    <= prev_z_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (close_acc) begin
      neg_x_q  <= scaled_x[SumW+FracBits-1];
      neg_y_q  <= scaled_y[SumW+FracBits-1];
      neg_z_q  <= scaled_z[SumW+FracBits-1];
      neg_t_q  <= temp5[RawW+2];
      gyro_x_q <= s_axis_tdata[79:64];
      gyro_y_q <= s_axis_tdata[95:80];
      gyro_z_q <= s_axis_tdata[111:96];
    end
    if (state_q == S_MEAN) begin
      mean_x_q <= mean_x_new;
      mean_y_q <= mean_y_new;
      mean_z_q <= mean_z_new;
      temp_q   <= temp_new;
    end
    if (state_q == S_HSUM) begin
      hsum_q <= HsumW'(hist_q[0]) + HsumW'(hist_q[1]) + HsumW'(hist_q[2]);
    end
    if (state_q == S_LOAD) begin
      neg_h_q <= hsum_q[HsumW-1];
    end
    if (state_q == S_NOW) begin
      now_q <= now_new;
    end
    if ((state_q == S_FINISH) && out_free) begin
      out_data_q <= {alert, change, gyro_z_q, gyro_y_q, gyro_x_q, temp_q,
                     mean_z_q, mean_y_q, mean_x_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(MaxWindow))
    else $error("window sample count exceeds the window size");

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != '0) && (fill_q <= FillW'(HistDepth)))
    else $error("history fill count out of range");

  a_close_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    close_acc |=> (state_q == S_DIV) && (count_q == '0) && (step_cnt_q == '0))
    else $error("close transaction did not clear the window and start division");

  a_cnt_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q != S_DIV) && (state_q != S_DIV2)) |-> (step_cnt_q == '0))
    else $error("division step counter running outside a division pass");

  a_result_on_finish : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_FINISH) && out_free) |=> out_valid_q && (state_q == S_IDLE))
    else $error("finished close did not present a result");

endmodule
